FILE: src/tmq_pkg.sv
package tmq_pkg;

	typedef enum logic [2:0] {
		MODE_CREATE  = 3'd0,
		MODE_GET     = 3'd1,
		MODE_DESTROY = 3'd2,
		MODE_SEND    = 3'd3,
		MODE_RECV    = 3'd4,
		MODE_PEEK    = 3'd5
	} mode_t;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_ERR   = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [2:0]  mode;
		logic [3:0]  qid;
		logic [31:0] key;
		logic [31:0] msg_type;
		logic [15:0] length_bytes;
		logic [63:0] data_word;
		logic        last_word;
	} tmq_in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  queue_id;
		logic [5:0]  msg_count;
		logic [8:0]  length_out;
		logic [63:0] data_out;
		logic        last_out;
		logic [4:0]  active_queues;
	} tmq_out_t;

endpackage

FILE: src/tmq_ram.sv
module tmq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: src/typed_message_queue_engine.sv
// Operation: create/get walk the slot table; send words are staged, and the
// closing word copies the message into the queue word by word; receive scans
// entries for a matching type, streams the message one word at a time, then a
// filtered receive shifts later entries down.
// One transaction at a time; busy stays high throughout. Results cannot be held.
// Reset (arst_n low) clears the slot table and staging count; stores need none.
module typed_message_queue_engine
	import tmq_pkg::*;
#(
	parameter int NUM_QUEUES  = 16,
	parameter int QUEUE_DEPTH = 32,
	parameter int MSG_BYTES   = 256
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  tmq_in_t  cmd,
	output logic     busy,
	output logic     done,
	output tmq_out_t result
);

	localparam int WORDS = (MSG_BYTES + 7) / 8;
	localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int WW = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = $clog2(WORDS + 1);
	localparam int LW = $clog2(MSG_BYTES + 1);
	localparam int EN = NUM_QUEUES * QUEUE_DEPTH;
	localparam int EW = $clog2(EN);
	localparam int DW = $clog2(EN * WORDS);
	localparam int AW = $clog2(NUM_QUEUES + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_KEY, S_STAGE, S_SCOPY, S_SCOPY2, S_RSCAN, S_RSCAN2, S_RSCAN3,
		S_RSIZE, S_ROUT, S_ROUT2, S_SHIFT, S_SHIFT2, S_FIN
	} state_t;

	state_t state_q;
	tmq_in_t cmd_q;

	logic [NUM_QUEUES-1:0] valid_q;
	logic [31:0] key_q [NUM_QUEUES];
	logic [31:0] ref_q [NUM_QUEUES];
	logic [PW-1:0] rp_q [NUM_QUEUES];
	logic [PW-1:0] wp_q [NUM_QUEUES];
	logic [CW-1:0] fill_q [NUM_QUEUES];
	logic [SW-1:0] stg_idx_q;

	logic [QW:0]   scan_q;   // slot scan counter
	logic [QW-1:0] q_q;
	logic [CW-1:0] p_q;      // entry offset counter
	logic [SW-1:0] w_q;      // word counter
	logic [SW-1:0] nw_q;
	logic [LW-1:0] copy_q;
	logic          found_q;
	logic [QW-1:0] free_q;
	logic          free_ok_q;

	logic          ty_we, sz_we, pl_we, sg_we;
	logic [EW-1:0] ty_wa, ty_ra;
	logic [31:0]   ty_wd, ty_rd;
	logic [LW-1:0] sz_wd, sz_rd;
	logic [DW-1:0] pl_wa, pl_ra;
	logic [63:0]   pl_wd, pl_rd;
	logic [WW-1:0] sg_wa, sg_ra;
	logic [63:0]   sg_rd;

	tmq_ram #(.WIDTH(32), .DEPTH(EN)) u_type (
		.clk, .we(ty_we), .waddr(ty_wa), .wdata(ty_wd), .raddr(ty_ra), .rdata(ty_rd));
	tmq_ram #(.WIDTH(LW), .DEPTH(EN)) u_size (
		.clk, .we(sz_we), .waddr(ty_wa), .wdata(sz_wd), .raddr(ty_ra), .rdata(sz_rd));
	tmq_ram #(.WIDTH(64), .DEPTH(EN * WORDS)) u_pay (
		.clk, .we(pl_we), .waddr(pl_wa), .wdata(pl_wd), .raddr(pl_ra), .rdata(pl_rd));
	tmq_ram #(.WIDTH(64), .DEPTH(WORDS)) u_stage (
		.clk, .we(sg_we), .waddr(sg_wa), .wdata(cmd_q.data_word), .raddr(sg_ra),
		.rdata(sg_rd));

	// entry index of offset off in the selected queue
	function automatic logic [EW-1:0] ent(input logic [QW-1:0] q, input logic [PW-1:0] rp,
		input logic [CW-1:0] off);
		logic [PW:0] s;
		s = {1'b0, rp} + (PW+1)'(off);
		if (s >= (PW+1)'(QUEUE_DEPTH)) s = s - (PW+1)'(QUEUE_DEPTH);
		return EW'(q) * EW'(QUEUE_DEPTH) + EW'(s[PW-1:0]);
	endfunction

	logic [AW-1:0] active;
	always_comb begin
		active = '0;
		for (int i = 0; i < NUM_QUEUES; i++) active = active + AW'(valid_q[i]);
	end

	logic qok;
	assign qok = (32'(cmd_q.qid) < NUM_QUEUES) && valid_q[q_q];

	logic [EW-1:0] cur_e, nxt_e;
	assign cur_e = ent(q_q, rp_q[q_q], p_q);
	assign nxt_e = ent(q_q, rp_q[q_q], p_q + CW'(1));
	logic [EW-1:0] wr_e;
	assign wr_e = EW'(q_q) * EW'(QUEUE_DEPTH) + EW'(wp_q[q_q]);

	// memory port drive
	always_comb begin
		ty_we = 1'b0; sz_we = 1'b0; pl_we = 1'b0; sg_we = 1'b0;
		ty_wa = wr_e; ty_wd = cmd_q.msg_type; sz_wd = LW'(cmd_q.length_bytes);
		ty_ra = cur_e;
		pl_wa = DW'(wr_e) * DW'(WORDS) + DW'(w_q);
		pl_wd = sg_rd;
		pl_ra = DW'(cur_e) * DW'(WORDS) + DW'(w_q);
		sg_wa = stg_idx_q[WW-1:0];
		sg_ra = w_q[WW-1:0];
		unique case (state_q)
			S_STAGE: sg_we = (stg_idx_q < SW'(WORDS));
			S_SCOPY2: begin
				pl_we = 1'b1;
				if (w_q == '0) begin
					ty_we = 1'b1; sz_we = 1'b1;
				end
			end
			S_SHIFT: begin
				ty_ra = nxt_e;
				pl_ra = DW'(nxt_e) * DW'(WORDS) + DW'(w_q);
			end
			S_SHIFT2: begin
				ty_wa = cur_e; ty_wd = ty_rd; sz_wd = sz_rd;
				pl_wa = pl_ra; pl_wd = pl_rd;
				ty_we = (w_q == '0); sz_we = (w_q == '0); pl_we = 1'b1;
				pl_wa = DW'(cur_e) * DW'(WORDS) + DW'(w_q);
			end
			default: ;
		endcase
	end

	logic [LW-1:0] rem;
	assign rem = copy_q - LW'({w_q, 3'b000});
	logic [63:0] mask;
	always_comb begin
		mask = '1;
		if (rem < LW'(8)) mask = ~(64'hFFFF_FFFF_FFFF_FFFF << {rem[2:0], 3'b000});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			stg_idx_q <= '0;
			q_q <= '0;
			done <= 1'b0;
			for (int i = 0; i < NUM_QUEUES; i++) begin
				key_q[i] <= '0; ref_q[i] <= '0; rp_q[i] <= '0; wp_q[i] <= '0;
				fill_q[i] <= '0;
			end
		end else begin
			done <= 1'b0;
			result <= '0;
			result.active_queues <= 5'(active);
			result.last_out <= 1'b1;
			unique case (state_q)
				S_IDLE: if (start) begin
					cmd_q <= cmd;
					q_q <= QW'(cmd.qid);
					scan_q <= '0; p_q <= '0; w_q <= '0;
					found_q <= 1'b0; free_ok_q <= 1'b0;
					unique case (cmd.mode)
						MODE_CREATE, MODE_GET: state_q <= S_KEY;
						MODE_SEND: state_q <= S_STAGE;
						default: state_q <= S_RSCAN;
					endcase
				end
				S_KEY: begin
					if (scan_q < (QW+1)'(NUM_QUEUES)) begin
						if (valid_q[scan_q[QW-1:0]] && key_q[scan_q[QW-1:0]] == cmd_q.key
							&& !found_q) begin
							found_q <= 1'b1; q_q <= scan_q[QW-1:0];
						end
						if (!valid_q[scan_q[QW-1:0]] && !free_ok_q) begin
							free_ok_q <= 1'b1; free_q <= scan_q[QW-1:0];
						end
						scan_q <= scan_q + 1'b1;
					end else begin
						state_q <= S_FIN;
						if (found_q) begin
							if (ref_q[q_q] != '1) ref_q[q_q] <= ref_q[q_q] + 1;
						end else if (cmd_q.mode == MODE_CREATE && free_ok_q) begin
							q_q <= free_q;
							valid_q[free_q] <= 1'b1; key_q[free_q] <= cmd_q.key;
							ref_q[free_q] <= 32'd1; rp_q[free_q] <= '0;
							wp_q[free_q] <= '0; fill_q[free_q] <= '0;
						end
					end
				end
				S_STAGE: begin
					if (stg_idx_q < SW'(WORDS)) stg_idx_q <= stg_idx_q + 1'b1;
					if (!cmd_q.last_word) state_q <= S_IDLE;
					else state_q <= S_SCOPY;
				end
				S_SCOPY: begin
					nw_q <= SW'((32'(cmd_q.length_bytes) + 7) >> 3);
					if (!(qok && cmd_q.length_bytes != 0 &&
						32'(cmd_q.length_bytes) <= MSG_BYTES &&
						32'(stg_idx_q) >= (32'(cmd_q.length_bytes) + 7) / 8 &&
						32'(fill_q[q_q]) < QUEUE_DEPTH)) begin
						stg_idx_q <= '0; done <= 1'b1; result.status <= ST_ERR;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_SCOPY2;
					end
				end
				S_SCOPY2: begin
					// staging RAM read of w_q is valid now
					if (w_q + 1'b1 == nw_q) begin
						wp_q[q_q] <= (32'(wp_q[q_q]) + 1 >= QUEUE_DEPTH) ? '0 : wp_q[q_q] + 1'b1;
						fill_q[q_q] <= fill_q[q_q] + 1'b1;
						stg_idx_q <= '0; done <= 1'b1; result.status <= ST_OK;
						state_q <= S_IDLE;
					end else begin
						w_q <= w_q + 1'b1; state_q <= S_SCOPY;
					end
				end
				S_RSCAN: begin
					if (cmd_q.mode == MODE_DESTROY) begin
						done <= 1'b1; state_q <= S_IDLE;
						if (!qok) result.status <= ST_ERR;
						else begin
							if (ref_q[q_q] <= 32'd1) begin
								ref_q[q_q] <= '0; valid_q[q_q] <= 1'b0; key_q[q_q] <= '0;
								rp_q[q_q] <= '0; wp_q[q_q] <= '0; fill_q[q_q] <= '0;
								result.active_queues <= 5'(active - 1'b1);
							end else ref_q[q_q] <= ref_q[q_q] - 1;
						end
					end else if (cmd_q.mode == MODE_PEEK) begin
						done <= 1'b1; state_q <= S_IDLE;
						if (!qok) result.status <= ST_ERR;
						else result.msg_count <= 6'(fill_q[q_q]);
					end else if (cmd_q.mode != MODE_RECV || !qok ||
						cmd_q.length_bytes == 0) begin
						done <= 1'b1; state_q <= S_IDLE; result.status <= ST_ERR;
					end else if (p_q >= fill_q[q_q]) begin
						done <= 1'b1; state_q <= S_IDLE; result.status <= ST_EMPTY;
					end else begin
						state_q <= S_RSCAN2;
					end
				end
				S_RSCAN2: state_q <= S_RSCAN3;   // type/size read in flight
				S_RSCAN3: begin
					if (cmd_q.msg_type == '0 || ty_rd == cmd_q.msg_type) begin
						copy_q <= (32'(sz_rd) < 32'(cmd_q.length_bytes)) ? sz_rd :
							LW'(cmd_q.length_bytes);
						state_q <= S_RSIZE;
					end else begin
						p_q <= p_q + 1'b1; state_q <= S_RSCAN;
					end
				end
				S_RSIZE: begin
					nw_q <= SW'((32'(copy_q) + 7) >> 3);
					state_q <= S_ROUT;
				end
				S_ROUT: state_q <= S_ROUT2;     // payload read in flight
				S_ROUT2: begin
					done <= 1'b1;
					result.length_out <= 9'(copy_q);
					result.data_out <= pl_rd & mask;
					result.last_out <= (w_q + 1'b1 == nw_q);
					if (w_q + 1'b1 != nw_q) begin
						w_q <= w_q + 1'b1; state_q <= S_ROUT;
					end else if (cmd_q.msg_type == '0) begin
						rp_q[q_q] <= (32'(rp_q[q_q]) + 1 >= QUEUE_DEPTH) ? '0 : rp_q[q_q] + 1'b1;
						fill_q[q_q] <= fill_q[q_q] - 1'b1;
						state_q <= S_IDLE;
					end else begin
						w_q <= '0; state_q <= S_FIN;
					end
				end
				S_SHIFT: state_q <= S_SHIFT2;
				S_SHIFT2: begin
					if (32'(w_q) + 1 < WORDS) begin
						w_q <= w_q + 1'b1; state_q <= S_SHIFT;
					end else begin
						w_q <= '0; p_q <= p_q + 1'b1; state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (cmd_q.mode == MODE_RECV) begin
						if (p_q + 1'b1 < fill_q[q_q]) state_q <= S_SHIFT;
						else begin
							wp_q[q_q] <= (wp_q[q_q] == '0) ? PW'(QUEUE_DEPTH - 1) : wp_q[q_q] - 1'b1;
							fill_q[q_q] <= fill_q[q_q] - 1'b1;
							state_q <= S_IDLE;
						end
					end else begin
						done <= 1'b1; state_q <= S_IDLE;
						if (found_q || (cmd_q.mode == MODE_CREATE && free_ok_q))
							result.queue_id <= 4'(q_q);
						else result.status <= ST_ERR;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !done || $past(busy)) else $error("result without transaction");
	a_stage_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(stg_idx_q) <= WORDS) else $error("staging index overrun");
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q[q_q]) <= QUEUE_DEPTH) else $error("fill level overrun");

endmodule
